>>> src/msp_tfp_pkg.sv
// ----------------------------------------------------------------------------
// msp_tfp_pkg
// Shared types, codes and the result field table of the telemetry frame parser.
// ----------------------------------------------------------------------------
package msp_tfp_pkg;

	// header bytes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	// decoded bytes live at payload offsets below this
	localparam int STORE_BYTES = 16;
	localparam int STORE_IDX_W = $clog2(STORE_BYTES);

	typedef logic [STORE_BYTES-1:0][7:0] store_t;

	// configuration register indexes
	localparam logic [2:0] CFG_ATTITUDE = 3'd0;
	localparam logic [2:0] CFG_ALTITUDE = 3'd1;
	localparam logic [2:0] CFG_RAW_GPS  = 3'd2;
	localparam logic [2:0] CFG_COMP_GPS = 3'd3;
	localparam logic [2:0] CFG_WAYPOINT = 3'd4;

	localparam logic [7:0] RST_ATTITUDE = 8'd108;
	localparam logic [7:0] RST_ALTITUDE = 8'd109;
	localparam logic [7:0] RST_RAW_GPS  = 8'd106;
	localparam logic [7:0] RST_COMP_GPS = 8'd107;
	localparam logic [7:0] RST_WAYPOINT = 8'd118;

	// gps update toggle bits
	localparam logic [2:0] TGL_COMP = 3'b001;
	localparam logic [2:0] TGL_RAW  = 3'b010;
	localparam logic [2:0] TGL_WP   = 3'b100;

	// result field ids
	localparam logic [3:0] FID_ALT     = 4'd0;
	localparam logic [3:0] FID_ROLL    = 4'd1;
	localparam logic [3:0] FID_PITCH   = 4'd2;
	localparam logic [3:0] FID_HEADING = 4'd3;
	localparam logic [3:0] FID_FIX     = 4'd4;
	localparam logic [3:0] FID_SATS    = 4'd5;
	localparam logic [3:0] FID_LAT     = 4'd6;
	localparam logic [3:0] FID_LON     = 4'd7;
	localparam logic [3:0] FID_GPSALT  = 4'd8;
	localparam logic [3:0] FID_SPEED   = 4'd9;
	localparam logic [3:0] FID_DIST    = 4'd10;
	localparam logic [3:0] FID_DIR     = 4'd11;
	localparam logic [3:0] FID_HOMELAT = 4'd12;
	localparam logic [3:0] FID_HOMELON = 4'd13;
	localparam logic [3:0] FID_MAX     = FID_HOMELON;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_START   = 6'b000010,
		PH_GOT_M   = 6'b000100,
		PH_ARROW   = 6'b001000,
		PH_SIZE    = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef enum logic [4:0] {
		KIND_ALT  = 5'b00001,
		KIND_ATT  = 5'b00010,
		KIND_RAW  = 5'b00100,
		KIND_COMP = 5'b01000,
		KIND_WP   = 5'b10000
	} kind_t;

	typedef enum logic [1:0] {
		FMT_U8  = 2'd0,
		FMT_U16 = 2'd1,
		FMT_S16 = 2'd2,
		FMT_W32 = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [7:0] attitude;
		logic [7:0] altitude;
		logic [7:0] raw_gps;
		logic [7:0] comp_gps;
		logic [7:0] waypoint;
	} codes_t;

	// frame end event from the framer to the decoder
	typedef struct packed {
		logic       done;
		logic [7:0] cmd;
	} frame_evt_t;

	typedef struct packed {
		logic [3:0]             id;
		logic [STORE_IDX_W-1:0] ofs;
		fmt_t                   fmt;
	} fld_ent_t;

	// index of the final result for a command kind
	function automatic logic [2:0] kind_last(kind_t kind);
		logic [2:0] n;
		unique case (kind)
			KIND_ALT:  n = 3'd0;
			KIND_ATT:  n = 3'd2;
			KIND_RAW:  n = 3'd5;
			KIND_COMP: n = 3'd1;
			KIND_WP:   n = 3'd1;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	// id, payload offset and format of result k of a command kind
	function automatic fld_ent_t fld_lookup(kind_t kind, logic [2:0] k);
		fld_ent_t e;
		e = '{id: FID_ALT, ofs: '0, fmt: FMT_W32};
		unique case (kind)
			KIND_ALT: e = '{id: FID_ALT, ofs: 4'd0, fmt: FMT_W32};
			KIND_ATT: begin
				case (k)
					3'd0:    e = '{id: FID_ROLL,    ofs: 4'd0, fmt: FMT_S16};
					3'd1:    e = '{id: FID_PITCH,   ofs: 4'd2, fmt: FMT_S16};
					default: e = '{id: FID_HEADING, ofs: 4'd4, fmt: FMT_S16};
				endcase
			end
			KIND_RAW: begin
				case (k)
					3'd0:    e = '{id: FID_FIX,    ofs: 4'd0,  fmt: FMT_U8};
					3'd1:    e = '{id: FID_SATS,   ofs: 4'd1,  fmt: FMT_U8};
					3'd2:    e = '{id: FID_LAT,    ofs: 4'd2,  fmt: FMT_W32};
					3'd3:    e = '{id: FID_LON,    ofs: 4'd6,  fmt: FMT_W32};
					3'd4:    e = '{id: FID_GPSALT, ofs: 4'd10, fmt: FMT_U16};
					default: e = '{id: FID_SPEED,  ofs: 4'd12, fmt: FMT_U16};
				endcase
			end
			KIND_COMP: begin
				case (k)
					3'd0:    e = '{id: FID_DIST, ofs: 4'd0, fmt: FMT_U16};
					default: e = '{id: FID_DIR,  ofs: 4'd2, fmt: FMT_U16};
				endcase
			end
			KIND_WP: begin
				case (k)
					3'd0:    e = '{id: FID_HOMELAT, ofs: 4'd1, fmt: FMT_W32};
					default: e = '{id: FID_HOMELON, ofs: 4'd5, fmt: FMT_W32};
				endcase
			end
			default: e = '{id: FID_ALT, ofs: 4'd0, fmt: FMT_W32};
		endcase
		return e;
	endfunction

endpackage

>>> src/msp_tfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// msp_tfp_cfg_regs
// Command code registers, written through a plain write port.
// ----------------------------------------------------------------------------
module msp_tfp_cfg_regs import msp_tfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output codes_t     codes
);

	codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '{attitude: RST_ATTITUDE, altitude: RST_ALTITUDE,
				raw_gps: RST_RAW_GPS, comp_gps: RST_COMP_GPS, waypoint: RST_WAYPOINT};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTITUDE: codes_q.attitude <= cfg_data;
				CFG_ALTITUDE: codes_q.altitude <= cfg_data;
				CFG_RAW_GPS:  codes_q.raw_gps  <= cfg_data;
				CFG_COMP_GPS: codes_q.comp_gps <= cfg_data;
				CFG_WAYPOINT: codes_q.waypoint <= cfg_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

>>> src/msp_tfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// msp_tfp_frame_fsm
// Header hunt, size and command capture, payload byte store.
// ----------------------------------------------------------------------------
module msp_tfp_frame_fsm import msp_tfp_pkg::*; #(
	parameter int PAYLOAD_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_vld,
	input  logic [7:0] rx_byte,
	output frame_evt_t evt,
	output store_t     store
);

	localparam logic [8:0] SIZE_LIMIT = 9'(PAYLOAD_MAX);

	phase_t     phase_q;
	logic [7:0] len_q;
	logic [7:0] cmd_q;
	logic [7:0] cnt_q;
	store_t     store_q;
	logic [8:0] cnt_inc;
	logic       frame_end;

	assign cnt_inc   = {1'b0, cnt_q} + 9'd1;
	assign frame_end = byte_vld && (phase_q == PH_PAYLOAD) && (cnt_inc >= {1'b0, len_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			cmd_q   <= '0;
			cnt_q   <= '0;
			store_q <= '0;
		end else if (byte_vld) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (rx_byte == CH_DOLLAR) phase_q <= PH_START;
				end
				PH_START: phase_q <= (rx_byte == CH_M) ? PH_GOT_M : PH_IDLE;
				PH_GOT_M: phase_q <= (rx_byte == CH_GT) ? PH_ARROW : PH_IDLE;
				PH_ARROW: begin
					if ({1'b0, rx_byte} > SIZE_LIMIT) begin
						phase_q <= PH_IDLE;
					end else begin
						len_q   <= rx_byte;
						phase_q <= PH_SIZE;
					end
				end
				PH_SIZE: begin
					cmd_q   <= rx_byte;
					phase_q <= PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					// bytes past the decoded window are never read back
					if (cnt_q[7:STORE_IDX_W] == '0) store_q[cnt_q[STORE_IDX_W-1:0]] <= rx_byte;
					if (frame_end) begin
						cnt_q   <= '0;
						phase_q <= PH_IDLE;
					end else begin
						cnt_q <= cnt_inc[7:0];
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign evt.done = frame_end;
	assign evt.cmd  = cmd_q;
	assign store    = store_q;

endmodule

>>> src/msp_tfp_decoder.sv
// ----------------------------------------------------------------------------
// msp_tfp_decoder
// Command match, gps toggles, one decoded value per cycle into the output register while it is not stalled.
// ----------------------------------------------------------------------------
module msp_tfp_decoder import msp_tfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_evt_t  evt,
	input  codes_t      codes,
	input  store_t      store,
	output logic        busy,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [3:0]  field_id,
	output logic [31:0] field_value,
	output logic [2:0]  flags,
	output logic        last
);

	kind_t      kind_sel;
	logic       known;
	logic [2:0] tgl;

	logic       active_q;
	kind_t      kind_q;
	logic [2:0] k_q;
	logic [2:0] last_k_q;
	logic [2:0] toggles_q;

	logic        tvalid_q;
	logic [3:0]  id_q;
	logic [31:0] value_q;
	logic [2:0]  flags_q;
	logic        last_q;

	fld_ent_t   ent;
	logic [7:0] b0, b1, b2, b3;
	logic [31:0] value;
	logic       load;

	// first match wins: altitude, attitude, raw gps, comp gps, waypoint
	always_comb begin
		known    = 1'b1;
		kind_sel = KIND_ALT;
		tgl      = '0;
		if (evt.cmd == codes.altitude) begin
			kind_sel = KIND_ALT;
		end else if (evt.cmd == codes.attitude) begin
			kind_sel = KIND_ATT;
		end else if (evt.cmd == codes.raw_gps) begin
			kind_sel = KIND_RAW;
			tgl      = TGL_RAW;
		end else if (evt.cmd == codes.comp_gps) begin
			kind_sel = KIND_COMP;
			tgl      = TGL_COMP;
		end else if (evt.cmd == codes.waypoint) begin
			kind_sel = KIND_WP;
			tgl      = TGL_WP;
		end else begin
			known = 1'b0;
		end
	end

	always_comb begin
		ent = fld_lookup(kind_q, k_q);
		b0  = store[ent.ofs];
		b1  = store[ent.ofs + STORE_IDX_W'(1)];
		b2  = store[ent.ofs + STORE_IDX_W'(2)];
		b3  = store[ent.ofs + STORE_IDX_W'(3)];
		case (ent.fmt)
			FMT_U8:  value = {24'd0, b0};
			FMT_U16: value = {16'd0, b1, b0};
			FMT_S16: value = {{16{b1[7]}}, b1, b0};
			default: value = {b3, b2, b1, b0};
		endcase
	end

	assign load = active_q && (!tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			kind_q    <= KIND_ALT;
			k_q       <= '0;
			last_k_q  <= '0;
			toggles_q <= '0;
			tvalid_q  <= 1'b0;
		end else begin
			if (evt.done) begin
				toggles_q <= toggles_q ^ tgl;
				active_q  <= known;
				kind_q    <= kind_sel;
				k_q       <= '0;
				last_k_q  <= kind_last(kind_sel);
			end else if (load) begin
				k_q <= k_q + 3'd1;
				if (k_q == last_k_q) active_q <= 1'b0;
			end
			if (load) tvalid_q <= 1'b1;
			else if (m_tready) tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q    <= ent.id;
			value_q <= value;
			flags_q <= toggles_q;
			last_q  <= (k_q == last_k_q);
		end
	end

	assign busy        = active_q;
	assign m_tvalid    = tvalid_q;
	assign field_id    = id_q;
	assign field_value = value_q;
	assign flags       = flags_q;
	assign last        = last_q;

endmodule

>>> src/msp_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// msp_telemetry_frame_parser
// Serial telemetry frame parser: header hunt, payload store, value decode.
// ----------------------------------------------------------------------------
// results: a frame's final payload byte passes the input register, the decoder
//   state and output register; results leave one per cycle while tready is high
// throughput: one byte per cycle; input is held off while a frame's 1 to 6
//   results drain from the decoder, set by its single output register
// reset: arst_n clears parse state, the payload byte store and the gps toggles,
//   and loads the default command codes
module msp_telemetry_frame_parser import msp_tfp_pkg::*; #(
	parameter int PAYLOAD_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// decoded values out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] field_value, [34:32] gps_update_flags,
	                                    // [39:35] zero
	output logic [3:0]  m_axis_tuser,   // [3:0] field_id
	output logic        m_axis_tlast,   // last_of_frame
	// command code registers
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        consume;
	logic        busy;
	codes_t      codes;
	frame_evt_t  evt;
	store_t      store;
	logic [3:0]  field_id;
	logic [31:0] field_value;
	logic [2:0]  flags;

	// input register; a held byte waits while the decoder drains a frame
	assign consume       = valid_s1 && !busy;
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	msp_tfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	// framer: one transfer per consumed byte, flags the final payload byte
	msp_tfp_frame_fsm #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (consume),
		.rx_byte  (byte_s1),
		.evt      (evt),
		.store    (store)
	);

	// decoder: matches the command at frame end and walks its value list
	msp_tfp_decoder u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.codes       (codes),
		.store       (store),
		.busy        (busy),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.field_id    (field_id),
		.field_value (field_value),
		.flags       (flags),
		.last        (m_axis_tlast)
	);

	// the field id says which value the data carries
	assign m_axis_tuser = field_id;
	assign m_axis_tdata = {5'b00000, flags, field_value};

endmodule

>>> src/msp_tfp_checker.sv
// ----------------------------------------------------------------------------
// msp_tfp_checker
// Port-level checks on the decoded value stream of the frame parser.
// ----------------------------------------------------------------------------
module msp_tfp_checker import msp_tfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= FID_MAX)
		else $error("field id out of range");

	// attitude angles are sign-extended 16-bit values
	a_sext: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == FID_ROLL || m_axis_tuser == FID_PITCH
			|| m_axis_tuser == FID_HEADING) |-> m_axis_tdata[31:16] == {16{m_axis_tdata[15]}})
		else $error("attitude value not sign-extended");

	// gps flags stay the same across one frame
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tdata[34:32]))
		else $error("gps flags changed within a frame");

endmodule

bind msp_telemetry_frame_parser msp_tfp_checker u_chk (.*);
